// ===== rtl/dbn_pkg.sv =====
// Shared types and constants for the multi-channel input debouncer.
package dbn_pkg;

  localparam int ChanW   = 3;
  localparam int KindW   = 2;
  localparam int AnalogW = 10;
  localparam int TimeW   = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  localparam int SDataW = 48;  // channel, button_level, analog_value, now_time, zero pad
  localparam int MDataW = 8;   // report_channel, stable_level, zero pad

  localparam int DefNumChannels = 8;

  localparam logic [AnalogW-1:0] MiddleRst   = AnalogW'(512);
  localparam logic [AnalogW-1:0] ToleranceRst = AnalogW'(100);
  localparam logic [TimeW-1:0]   DebounceRst = TimeW'(50);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REST_POINT = 2'd0,
    CFG_DEAD_BAND  = 2'd1,
    CFG_HOLD_TIME  = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_t;

  typedef enum logic [KindW-1:0] {
    KIND_BUTTON   = 2'd0,
    KIND_AXIS_NEG = 2'd1,
    KIND_AXIS_POS = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  // classified sample
  typedef struct packed {
    logic ok;     // known kind and channel in range
    logic level;  // 1 active
  } class_t;

  // per-channel decision for the sample in the input register
  typedef struct packed {
    logic fire;
    logic first;
    logic level;
  } stat_t;

endpackage

// ===== rtl/dbn_classify.sv =====
// Sample classification: source kind and raw reading to an active level.
module dbn_classify #(
  parameter int NUM_CHANNELS = dbn_pkg::DefNumChannels
) (
  input  logic [dbn_pkg::ChanW-1:0]   channel,
  input  logic [dbn_pkg::KindW-1:0]   source_kind,
  input  logic                        button_level,
  input  logic [dbn_pkg::AnalogW-1:0] analog_value,
  input  logic [dbn_pkg::AnalogW-1:0] rest_point,
  input  logic [dbn_pkg::AnalogW-1:0] dead_band,
  output dbn_pkg::class_t             cls
);
  import dbn_pkg::*;

  logic [AnalogW:0] lo_bound;
  logic [AnalogW:0] hi_bound;
  logic             neg_act;
  logic             pos_act;
  logic             in_range;

  // lower bound is negative when tolerance exceeds middle: never active then
  assign lo_bound = {1'b0, rest_point} - {1'b0, dead_band};
  assign hi_bound = {1'b0, rest_point} + {1'b0, dead_band};
  assign neg_act  = (dead_band <= rest_point) && ({1'b0, analog_value} < lo_bound);
  assign pos_act  = {1'b0, analog_value} > hi_bound;
  assign in_range = int'(channel) < NUM_CHANNELS;

  always_comb begin
    cls = '0;
    case (kind_t'(source_kind))
      KIND_BUTTON: begin
        cls.ok    = in_range;
        cls.level = ~button_level;
      end
      KIND_AXIS_NEG: begin
        cls.ok    = in_range;
        cls.level = neg_act;
      end
      KIND_AXIS_POS: begin
        cls.ok    = in_range;
        cls.level = pos_act;
      end
      default: cls = '0;
    endcase
  end

endmodule

// ===== rtl/dbn_chan_state.sv =====
// Per-channel pending/stable state and the report decision.
module dbn_chan_state #(
  parameter int NUM_CHANNELS = dbn_pkg::DefNumChannels,
  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      upd,
  input  logic [IdxW-1:0]           idx,
  input  dbn_pkg::class_t           cls,
  input  logic [dbn_pkg::TimeW-1:0] now_time,
  input  logic [dbn_pkg::TimeW-1:0] hold_time,
  output dbn_pkg::stat_t            st
);
  import dbn_pkg::*;

  logic             pending_level [NUM_CHANNELS];
  logic [TimeW-1:0] pending_since [NUM_CHANNELS];
  logic             stable_state  [NUM_CHANNELS];
  logic             first_pending [NUM_CHANNELS];

  logic             changed;
  logic [TimeW-1:0] since_next;
  logic [TimeW-1:0] deadline;

  assign changed    = cls.level != pending_level[idx];
  assign since_next = changed ? now_time : pending_since[idx];
  assign deadline   = since_next + hold_time;  // wraps at 32 bits

  always_comb begin
    st.first = first_pending[idx];
    st.level = cls.level;
    st.fire  = cls.ok && (((cls.level != stable_state[idx]) && (deadline < now_time))
                          || first_pending[idx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pending_level[i] <= 1'b0;
        pending_since[i] <= '0;
        stable_state[i]  <= 1'b0;
        first_pending[i] <= 1'b1;
      end
    end else if (upd && cls.ok) begin
      pending_level[idx] <= cls.level;
      pending_since[idx] <= since_next;
      if (st.fire) begin
        stable_state[idx]  <= cls.level;
        first_pending[idx] <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/multi_channel_input_debouncer.sv =====
// Top level of the multi-channel input debouncer.
//
//  port group   dir  transfer                          payload
//  s_axis_*     in   s_axis_tvalid & s_axis_tready     tdata: sample, tuser: source kind
//  m_axis_*     out  m_axis_tvalid & m_axis_tready     tdata: channel and stable level
//  cfg_*        in   cfg_valid & cfg_ready             cfg_index, cfg_data
//
// One sample per cycle sustained unless a stalled result holds the pipe; a report is offered
// on m_axis once the sample has passed the input register and then the result register.
// Channel state is read and written in the same cycle, so samples of the same
// channel may follow each other with no gap.
// A stalled result holds the pipe only when the sample in the input register
// would report; samples that report nothing keep flowing.
// Reset clears all channel state; cfg_ready is always high.
module multi_channel_input_debouncer #(
  parameter int NUM_CHANNELS = dbn_pkg::DefNumChannels
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] channel, [3] button_level, [13:4] analog_value, [45:14] now_time, [47:46] zero
  input  logic [dbn_pkg::SDataW-1:0]   s_axis_tdata,
  // [1:0] source_kind
  input  logic [dbn_pkg::KindW-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] report_channel, [3] stable_level, [7:4] zero
  output logic [dbn_pkg::MDataW-1:0]   m_axis_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dbn_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dbn_pkg::CfgW-1:0]     cfg_data
);
  import dbn_pkg::*;

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [AnalogW-1:0] rest_point;
  logic [AnalogW-1:0] dead_band;
  logic [TimeW-1:0]   hold_time;

  // input register
  logic               ir_valid;
  logic [ChanW-1:0]   ir_channel;
  logic [KindW-1:0]   ir_kind;
  logic               ir_button;
  logic [AnalogW-1:0] ir_analog;
  logic [TimeW-1:0]   ir_now;

  // result register
  logic [ChanW-1:0]   out_channel;
  logic               out_level;

  class_t cls;
  stat_t  st;
  logic   adv;
  logic   s_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_point <= MiddleRst;
      dead_band  <= ToleranceRst;
      hold_time  <= DebounceRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REST_POINT: rest_point <= cfg_data[AnalogW-1:0];
        CFG_DEAD_BAND:  dead_band  <= cfg_data[AnalogW-1:0];
        CFG_HOLD_TIME:  hold_time  <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // the item in the input register leaves unless it reports into a full, stalled output
  assign adv           = ir_valid && (!st.fire || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !ir_valid || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (s_axis_tready) begin
      ir_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      ir_channel <= s_axis_tdata[2:0];
      ir_button  <= s_axis_tdata[3];
      ir_analog  <= s_axis_tdata[13:4];
      ir_now     <= s_axis_tdata[45:14];
      ir_kind    <= s_axis_tuser;
    end
  end

  dbn_classify #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_classify (
    .channel      (ir_channel),
    .source_kind  (ir_kind),
    .button_level (ir_button),
    .analog_value (ir_analog),
    .rest_point   (rest_point),
    .dead_band    (dead_band),
    .cls          (cls)
  );

  dbn_chan_state #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_chan_state (
    .clk       (clk),
    .rst       (rst),
    .upd       (adv),
    .idx       (IdxW'(ir_channel)),
    .cls       (cls),
    .now_time  (ir_now),
    .hold_time (hold_time),
    .st        (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && st.fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st.fire) begin
      out_channel <= ir_channel;
      out_level   <= st.level;
    end
  end

  assign m_axis_tdata = {(MDataW - ChanW - 1)'(0), out_level, out_channel};

  // a valid sample of a channel that never reported must report
  a_first_reports: assert property (@(posedge clk) disable iff (rst)
    ir_valid && cls.ok && st.first |-> st.fire)
    else $error("first sample of a channel did not report");

  // a report leaving the input register lands in the result register
  a_report_loaded: assert property (@(posedge clk) disable iff (rst)
    adv && st.fire |=> m_axis_tvalid && (out_channel == $past(ir_channel)))
    else $error("report not loaded into result register");

  // an empty input register never blocks the slave side
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !ir_valid |-> s_axis_tready)
    else $error("input stalled while input register empty");

endmodule
